### hdl/psw_pkg.sv
// shared types and constants for the priority schedule wait-time block
// used by psw_div and priority_schedule_wait_times_top; depends on nothing
package psw_pkg;

  localparam int unsigned MaxJobs      = 16;
  localparam int unsigned BurstBits    = 16;
  localparam int unsigned PriorityBits = 8;
  localparam int unsigned IdW          = 4;   // load-order index of a job
  localparam int unsigned CntW         = 5;   // job count, holds MaxJobs itself
  localparam int unsigned WaitW        = 20;
  localparam int unsigned TotalW       = 24;
  localparam int unsigned FracBits     = 8;
  localparam int unsigned AvgW         = 28;
  localparam int unsigned DivW         = TotalW + FracBits;
  localparam int unsigned DivCntW      = 6;   // holds DivW itself
  localparam int unsigned InDataW      = 24;
  localparam int unsigned OutDataW     = 128;
  localparam int unsigned OutPadW      = OutDataW - (IdW + PriorityBits + BurstBits
                                         + 2 * WaitW + 2 * AvgW);

  // one stored job
  typedef struct packed {
    logic [IdW-1:0]          id;
    logic [PriorityBits-1:0] prio;
    logic [BurstBits-1:0]    burst;
  } entry_t;

  // result beat payload, last member in the lowest bits
  typedef struct packed {
    logic [OutPadW-1:0]      pad;
    logic [AvgW-1:0]         avg_turnaround_q8;
    logic [AvgW-1:0]         avg_waiting_q8;
    logic [WaitW-1:0]        turnaround_time;
    logic [WaitW-1:0]        waiting_time;
    logic [BurstBits-1:0]    job_burst;
    logic [PriorityBits-1:0] job_priority;
    logic [IdW-1:0]          job_id;
  } out_data_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/psw_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// divides a DivW-bit total by the job count; depends on psw_pkg
module psw_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psw_pkg::div_req_t  req_i,
  output psw_pkg::div_rsp_t  rsp_o
);

  logic [psw_pkg::CntW-1:0]    rem_q, rem_d;
  logic [psw_pkg::DivW-1:0]    quo_q;
  logic [psw_pkg::CntW-1:0]    divisor_q;
  logic [psw_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [psw_pkg::CntW:0]      trial;
  logic                        ge;

  assign trial = {rem_q, quo_q[psw_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, divisor_q};

  always_comb begin
    if (ge) begin
      rem_d = psw_pkg::CntW'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[psw_pkg::CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      quo_q     <= '0;
      divisor_q <= '0;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q     <= '0;
        quo_q     <= req_i.dividend;
        divisor_q <= req_i.divisor;
        cnt_q     <= psw_pkg::DivCntW'(psw_pkg::DivW);
        busy_q    <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[psw_pkg::DivW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == psw_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hdl/priority_schedule_wait_times_top.sv
// non-preemptive priority scheduler: job store, exchange sort, wait and turnaround rows
// depends on psw_pkg and psw_div
//
// Usage: jobs arrive as beats on the slave stream (tdata = burst, priority; tlast
// closes the set). Up to MaxJobs jobs are held in a 16-entry job memory, numbered
// in load order; further jobs are dropped and flagged. Loading takes one beat per
// cycle. After the tlast beat tready drops while the set is sorted in place in the
// memory: the entry at position i sits in a register while positions i+1..n-1 are
// read one per cycle and exchanged through the single write port. One row per job
// then leaves on the master stream in run order, each through a memory read, a row
// build and a handshake; a receiver stall simply holds the output register and the
// sequencer. The summary beat (tuser bit 0, with tlast) follows after two divisions in
// a bit-serial divider that is shared by both averages. Once the summary beat is
// taken tready rises again for a new set. Reset clears the job count, flags and
// sums and leaves the memory as it is; no clearing pass is needed because only
// written entries are ever used.
module priority_schedule_wait_times_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] burst_time, [23:16] priority_req
  input  logic [psw_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] job_id, [11:4] job_priority, [27:12] job_burst, [47:28] waiting_time,
  // [67:48] turnaround_time, [95:68] avg_waiting_q8, [123:96] avg_turnaround_q8, zero pad
  output logic [psw_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] is_summary, [1] overflow
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_HEAD,
    ST_SCAN,
    ST_WB,
    ST_ISSUE,
    ST_ROW,
    ST_ROW_HOLD,
    ST_DIV_WAIT,
    ST_DIV_TAT,
    ST_SUM
  } state_e;

  state_e                          state_q;
  logic [psw_pkg::CntW-1:0]        cnt_q;
  logic                            dropped_q;
  logic [psw_pkg::IdW-1:0]         i_q, j_q, k_q;
  psw_pkg::entry_t                 cur_q;
  logic [psw_pkg::WaitW-1:0]       rw_q;
  logic [psw_pkg::TotalW-1:0]      tw_q, tt_q;
  logic [psw_pkg::AvgW-1:0]        aw_q;
  logic                            div_start_q;
  logic                            m_valid_q;
  psw_pkg::out_data_t              m_data_q;
  logic [1:0]                      m_user_q;
  logic                            m_last_q;

  // job memory
  psw_pkg::entry_t                 mem_q [psw_pkg::MaxJobs];
  psw_pkg::entry_t                 rd_q;
  logic                            wr_en;
  logic [psw_pkg::IdW-1:0]         wr_addr, rd_addr;
  psw_pkg::entry_t                 wr_data;

  logic                            in_acc, out_acc, has_room, swap;
  logic [psw_pkg::CntW-1:0]        n_next, last_idx;
  logic [psw_pkg::WaitW-1:0]       tat;
  psw_pkg::entry_t                 in_entry;
  psw_pkg::div_req_t               div_req;
  psw_pkg::div_rsp_t               div_rsp;
  logic [psw_pkg::AvgW-1:0]        avg;
  psw_pkg::out_data_t              row_data, sum_data;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_valid_q && m_axis_tready_i;
  assign has_room = cnt_q < psw_pkg::CntW'(psw_pkg::MaxJobs);
  assign n_next   = has_room ? cnt_q + 1'b1 : cnt_q;
  assign last_idx = cnt_q - 1'b1;
  assign swap     = cur_q.prio < rd_q.prio;
  assign tat      = rw_q + psw_pkg::WaitW'(rd_q.burst);

  assign in_entry.id    = cnt_q[psw_pkg::IdW-1:0];
  assign in_entry.prio  = s_axis_tdata_i[psw_pkg::BurstBits +: psw_pkg::PriorityBits];
  assign in_entry.burst = s_axis_tdata_i[psw_pkg::BurstBits-1:0];

  // an empty set cannot occur, but keep its averages at zero
  assign avg = (cnt_q == '0) ? '0 : div_rsp.quotient[psw_pkg::AvgW-1:0];

  // job row and summary row payloads
  always_comb begin
    row_data                   = '0;
    row_data.job_id            = rd_q.id;
    row_data.job_priority      = rd_q.prio;
    row_data.job_burst         = rd_q.burst;
    row_data.waiting_time      = rw_q;
    row_data.turnaround_time   = tat;
    sum_data                   = '0;
    sum_data.avg_waiting_q8    = aw_q;
    sum_data.avg_turnaround_q8 = avg;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_q;
    wr_data = cur_q;
    rd_addr = k_q;
    unique case (state_q)
      ST_LOAD: begin
        wr_en   = in_acc && has_room;
        wr_addr = cnt_q[psw_pkg::IdW-1:0];
        wr_data = in_entry;
      end
      ST_START: rd_addr = i_q;
      ST_HEAD:  rd_addr = i_q + 1'b1;
      ST_SCAN: begin
        wr_en   = swap;
        wr_addr = j_q;
        rd_addr = j_q + 1'b1;
      end
      ST_WB:    wr_en = 1'b1;
      default:  rd_addr = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign div_req.start    = div_start_q;
  assign div_req.dividend = (state_q == ST_DIV_TAT) ? {tt_q, psw_pkg::FracBits'(0)}
                                                    : {tw_q, psw_pkg::FracBits'(0)};
  assign div_req.divisor  = cnt_q;

  psw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cur_q       <= '0;
      rw_q        <= '0;
      tw_q        <= '0;
      tt_q        <= '0;
      aw_q        <= '0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              dropped_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              i_q  <= '0;
              k_q  <= '0;
              rw_q <= '0;
              if (n_next >= psw_pkg::CntW'(2)) begin
                state_q <= ST_START;
              end else begin
                state_q <= ST_ISSUE;
              end
            end
          end
        end
        ST_START: state_q <= ST_HEAD;
        ST_HEAD: begin
          cur_q   <= rd_q;
          j_q     <= i_q + 1'b1;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // the held entry trades places with any later one of higher priority
          if (swap) begin
            cur_q <= rd_q;
          end
          if (j_q == last_idx[psw_pkg::IdW-1:0]) begin
            state_q <= ST_WB;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_WB: begin
          if ({1'b0, i_q} + psw_pkg::CntW'(2) == cnt_q) begin
            state_q <= ST_ISSUE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_START;
          end
        end
        ST_ISSUE: state_q <= ST_ROW;
        ST_ROW: begin
          m_data_q  <= row_data;
          m_user_q  <= '0;
          m_last_q  <= 1'b0;
          m_valid_q <= 1'b1;
          tw_q      <= tw_q + psw_pkg::TotalW'(rw_q);
          tt_q      <= tt_q + psw_pkg::TotalW'(tat);
          rw_q      <= tat;
          state_q   <= ST_ROW_HOLD;
        end
        ST_ROW_HOLD: begin
          if (out_acc) begin
            m_valid_q <= 1'b0;
            if (k_q == last_idx[psw_pkg::IdW-1:0]) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV_WAIT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            aw_q        <= avg;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_TAT;
          end
        end
        ST_DIV_TAT: begin
          if (div_rsp.done) begin
            m_data_q  <= sum_data;
            m_user_q  <= {dropped_q, 1'b1};
            m_last_q  <= 1'b1;
            m_valid_q <= 1'b1;
            state_q   <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_acc) begin
            m_valid_q <= 1'b0;
            cnt_q     <= '0;
            dropped_q <= 1'b0;
            rw_q      <= '0;
            tw_q      <= '0;
            tt_q      <= '0;
            state_q   <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // loading and emitting never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_valid_q))
    else $error("input accepted while a result beat is pending");

  // the summary beat is the one that ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_user_q[0] == m_last_q))
    else $error("summary flag and tlast disagree");

  // the job count never passes the store capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= psw_pkg::CntW'(psw_pkg::MaxJobs))
    else $error("job count beyond capacity");

  // the divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a taken summary beat reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_last_q) |=> s_axis_tready_o)
    else $error("input not reopened after summary");

endmodule
